// File: rtl/bgi_pkg.sv
package bgi_pkg;

    localparam int PIXEL_W = 8;
    localparam int INDEX_W = 20;
    localparam int PLANE_W = 2;
    localparam int CFG_W   = 11;
    localparam int TDATA_W = 32;
    localparam int TUSER_W = 3;
    localparam int S_TDATA_W = 8;

    typedef logic [PLANE_W-1:0] plane_t;
    typedef logic [1:0] kind_t;

    localparam plane_t PLANE_RED   = 2'd0;
    localparam plane_t PLANE_GREEN = 2'd1;
    localparam plane_t PLANE_BLUE  = 2'd2;

    localparam kind_t KIND_NONE = 2'd0;
    localparam kind_t KIND_HORZ = 2'd1;
    localparam kind_t KIND_VERT = 2'd2;
    localparam kind_t KIND_QUAD = 2'd3;

    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    localparam logic [CFG_W-1:0] COLUMNS_RESET = 11'd640;
    localparam logic [CFG_W-1:0] ROWS_RESET    = 11'd480;

    typedef struct packed {
        kind_t               kind;
        logic                parity;
        logic                last_col;
        logic                eof;
        plane_t              plane;
        logic [INDEX_W-1:0]  idx0;
        logic [INDEX_W-1:0]  idx1;
        logic [PIXEL_W-1:0]  pixel;
        logic [PIXEL_W-1:0]  last_green;
    } bgi_item_t;

endpackage

// File: rtl/bayer_green_interpolator_core.sv
// An accepted pixel is registered in the front stage (s1), then in the output register
// that puts its first result beat on the bus.
// Throughput: one pixel per cycle while m_tready is high; a pixel that also completes an
// interpolated green causes two beats and holds the single result channel, and the pipeline.
// Reset clears the frame position, the plane indices, the held green and the pipeline;
// the green line memories are not cleared, and geometry returns to 640 by 480.
module bayer_green_interpolator_core import bgi_pkg::*; #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // pixel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // index, value, zero fill
    output logic [TUSER_W-1:0]   m_tuser,   // plane, last_of_item
    output logic                 m_tlast    // end_of_frame
);

    localparam int COL_W     = $clog2(MAX_COLUMNS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int ColsLimit = MAX_COLUMNS - (MAX_COLUMNS % 2);

    logic [CFG_W-1:0]   columns_reg;
    logic [CFG_W-1:0]   rows_reg;
    logic [COL_W-1:0]   cols_m1;
    logic [ROW_W-1:0]   rows_m1;
    logic [INDEX_W-1:0] cols_step;

    logic               take;
    logic               s1_valid;
    bgi_item_t          s1_item;
    logic               even_we;
    logic               odd_we;
    logic [COL_W-1:0]   wr_addr;
    logic [PIXEL_W-1:0] wr_data;
    logic               rd_en;
    logic [COL_W-1:0]   even_raddr;
    logic [COL_W-1:0]   odd_raddr;
    logic [PIXEL_W-1:0] even_rdata;
    logic [PIXEL_W-1:0] odd_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= COLUMNS_RESET;
            rows_reg    <= ROWS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_COLUMNS: columns_reg <= cfg_wdata;
                REG_ROWS:    rows_reg    <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    always_comb begin
        int cols_v;
        int rows_v;
        cols_v = int'({columns_reg[CFG_W-1:1], 1'b0});
        if (cols_v < 2) begin
            cols_v = 2;
        end
        if (cols_v > ColsLimit) begin
            cols_v = ColsLimit;
        end
        rows_v = int'(rows_reg);
        if (rows_v < 2) begin
            rows_v = 2;
        end
        if (rows_v > MAX_ROWS) begin
            rows_v = MAX_ROWS;
        end
        cols_m1   = COL_W'(cols_v - 1);
        rows_m1   = ROW_W'(rows_v - 1);
        cols_step = INDEX_W'(cols_v);
    end

    bgi_front #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_restart (cfg_we),
        .cols_m1     (cols_m1),
        .rows_m1     (rows_m1),
        .cols_step   (cols_step),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .pixel       (s_tdata[PIXEL_W-1:0]),
        .take        (take),
        .s1_valid    (s1_valid),
        .s1_item     (s1_item),
        .even_we     (even_we),
        .odd_we      (odd_we),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .even_raddr  (even_raddr),
        .odd_raddr   (odd_raddr)
    );

    bgi_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_COLUMNS)
    ) u_even_line (
        .aclk  (aclk),
        .we    (even_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (even_raddr),
        .rdata (even_rdata)
    );

    bgi_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_COLUMNS)
    ) u_odd_line (
        .aclk  (aclk),
        .we    (odd_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (odd_raddr),
        .rdata (odd_rdata)
    );

    bgi_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item),
        .take       (take),
        .even_rdata (even_rdata),
        .odd_rdata  (odd_rdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// File: rtl/bgi_ram.sv
module bgi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/bgi_front.sv
module bgi_front import bgi_pkg::*; #(
    parameter int COL_W = 10,
    parameter int ROW_W = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_restart,
    input  logic [COL_W-1:0]   cols_m1,
    input  logic [ROW_W-1:0]   rows_m1,
    input  logic [INDEX_W-1:0] cols_step,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [PIXEL_W-1:0] pixel,
    input  logic               take,
    output logic               s1_valid,
    output bgi_item_t          s1_item,
    output logic               even_we,
    output logic               odd_we,
    output logic [COL_W-1:0]   wr_addr,
    output logic [PIXEL_W-1:0] wr_data,
    output logic               rd_en,
    output logic [COL_W-1:0]   even_raddr,
    output logic [COL_W-1:0]   odd_raddr
);

    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [INDEX_W-1:0] red_reg;
    logic [INDEX_W-1:0] blue_reg;
    logic [INDEX_W-1:0] base_reg;
    logic [INDEX_W-1:0] prev_reg;
    logic [PIXEL_W-1:0] last_green_reg;
    logic               s1_valid_reg;
    bgi_item_t          s1_reg;

    logic               accept;
    logic               parity;
    logic               is_green;
    logic               is_red;
    logic               last_col;
    logic               last_row;
    logic               c_ge3;
    logic               r_ge3;
    logic [COL_W-1:0]   other_addr;
    bgi_item_t          item_next;

    assign s_tready = !s1_valid_reg || take;
    assign accept   = s_tvalid && s_tready;

    assign parity     = row_reg[0];
    assign is_green   = row_reg[0] ^ col_reg[0];
    assign is_red     = !row_reg[0] && !col_reg[0];
    assign last_col   = (col_reg == cols_m1);
    assign last_row   = (row_reg == rows_m1);
    assign c_ge3      = (32'(col_reg) >= 32'd3);
    assign r_ge3      = (32'(row_reg) >= 32'd3);
    assign other_addr = col_reg + 1'b1;

    always_comb begin
        item_next            = '0;
        item_next.parity     = parity;
        item_next.last_col   = last_col;
        item_next.eof        = last_col && last_row;
        item_next.pixel      = pixel;
        item_next.last_green = last_green_reg;
        item_next.kind       = KIND_NONE;
        if (is_green) begin
            item_next.plane = PLANE_GREEN;
            item_next.idx0  = base_reg + INDEX_W'(col_reg);
            if (row_reg == '0) begin
                item_next.kind = c_ge3 ? KIND_HORZ : KIND_NONE;
            end else if (!parity) begin
                item_next.kind = c_ge3 ? KIND_QUAD : KIND_NONE;
            end else if (r_ge3) begin
                item_next.kind = (col_reg == '0) ? KIND_VERT : KIND_QUAD;
            end
        end else if (is_red) begin
            item_next.plane = PLANE_RED;
            item_next.idx0  = red_reg;
        end else begin
            item_next.plane = PLANE_BLUE;
            item_next.idx0  = blue_reg;
        end
        unique case (item_next.kind)
            KIND_HORZ: item_next.idx1 = INDEX_W'(col_reg) - 1'b1;
            KIND_VERT: item_next.idx1 = prev_reg;
            KIND_QUAD: item_next.idx1 = prev_reg + INDEX_W'(col_reg);
            default:   item_next.idx1 = '0;
        endcase
    end

    assign even_we    = accept && is_green && !parity;
    assign odd_we     = accept && is_green && parity;
    assign wr_addr    = col_reg;
    assign wr_data    = pixel;
    assign rd_en      = accept && is_green;
    assign even_raddr = parity ? other_addr : col_reg;
    assign odd_raddr  = parity ? col_reg : other_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            red_reg        <= '0;
            blue_reg       <= '0;
            base_reg       <= '0;
            prev_reg       <= '0;
            last_green_reg <= '0;
            s1_valid_reg   <= 1'b0;
        end else begin
            if (cfg_restart) begin
                col_reg  <= '0;
                row_reg  <= '0;
                red_reg  <= '0;
                blue_reg <= '0;
                base_reg <= '0;
                prev_reg <= '0;
            end else if (accept) begin
                if (is_green) begin
                    last_green_reg <= pixel;
                end
                if (last_col && last_row) begin
                    col_reg  <= '0;
                    row_reg  <= '0;
                    red_reg  <= '0;
                    blue_reg <= '0;
                    base_reg <= '0;
                    prev_reg <= '0;
                end else begin
                    if (is_red) begin
                        red_reg <= red_reg + 1'b1;
                    end
                    if (!is_green && !is_red) begin
                        blue_reg <= blue_reg + 1'b1;
                    end
                    if (last_col) begin
                        col_reg  <= '0;
                        row_reg  <= row_reg + 1'b1;
                        prev_reg <= base_reg;
                        base_reg <= base_reg + cols_step;
                    end else begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (take) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= item_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_reg;

endmodule

// File: rtl/bgi_out.sv
module bgi_out import bgi_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s1_valid,
    input  bgi_item_t          s1_item,
    output logic               take,
    input  logic [PIXEL_W-1:0] even_rdata,
    input  logic [PIXEL_W-1:0] odd_rdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic [TUSER_W-1:0] m_tuser,
    output logic               m_tlast
);

    logic               valid_reg;
    logic               sel_reg;
    logic               has2_reg;
    logic               eof_reg;
    plane_t             plane_reg;
    logic [INDEX_W-1:0] idx0_reg;
    logic [INDEX_W-1:0] idx1_reg;
    logic [PIXEL_W-1:0] val0_reg;
    logic [PIXEL_W-1:0] val1_reg;
    logic [PIXEL_W-1:0] left_reg;

    logic [PIXEL_W-1:0] up;
    logic [PIXEL_W-1:0] oth;
    logic [PIXEL_W-1:0] right;
    logic [PIXEL_W-1:0] pair_a;
    logic [PIXEL_W+1:0] quad_sum;
    logic [PIXEL_W:0]   pair_sum;
    logic [PIXEL_W-1:0] val1_next;
    logic               last_beat;
    logic               done;

    assign up     = s1_item.parity ? odd_rdata : even_rdata;
    assign oth    = s1_item.parity ? even_rdata : odd_rdata;
    assign right  = s1_item.last_col ? left_reg : oth;
    assign pair_a = (s1_item.kind == KIND_HORZ) ? s1_item.last_green : up;

    assign quad_sum = (PIXEL_W+2)'(2) + (PIXEL_W+2)'(up) + (PIXEL_W+2)'(left_reg)
                    + (PIXEL_W+2)'(s1_item.pixel) + (PIXEL_W+2)'(right);
    assign pair_sum = (PIXEL_W+1)'(1) + (PIXEL_W+1)'(pair_a) + (PIXEL_W+1)'(s1_item.pixel);
    assign val1_next = (s1_item.kind == KIND_QUAD) ? quad_sum[PIXEL_W+1:2]
                                                   : pair_sum[PIXEL_W:1];

    assign last_beat = !has2_reg || sel_reg;
    assign done      = valid_reg && m_tready && last_beat;
    assign take      = s1_valid && (!valid_reg || done);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else if (take) begin
            valid_reg <= 1'b1;
            sel_reg   <= 1'b0;
        end else if (done) begin
            valid_reg <= 1'b0;
        end else if (valid_reg && m_tready) begin
            sel_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            has2_reg  <= (s1_item.kind != KIND_NONE);
            eof_reg   <= s1_item.eof;
            plane_reg <= s1_item.plane;
            idx0_reg  <= s1_item.idx0;
            idx1_reg  <= s1_item.idx1;
            val0_reg  <= s1_item.pixel;
            val1_reg  <= val1_next;
            if (s1_item.plane == PLANE_GREEN) begin
                left_reg <= oth;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {(TDATA_W-INDEX_W-PIXEL_W)'(0),
                       sel_reg ? val1_reg : val0_reg,
                       sel_reg ? idx1_reg : idx0_reg};
    assign m_tuser  = {last_beat, sel_reg ? PLANE_GREEN : plane_reg};
    assign m_tlast  = eof_reg && last_beat;

endmodule
